// ===== design/imtwa_pkg.sv =====
// shared constants, types and helpers for the imu time window averager
package imtwa_pkg;

    localparam int MAX_BATCH   = 4096;
    localparam int SAMPLE_BITS = 32;
    localparam int FIELD_W     = 32;
    localparam int TIME_W      = 64;
    localparam int OFF_W       = 32;
    localparam int CNT_W       = $clog2(MAX_BATCH + 1);
    localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_BATCH) + 1;
    localparam int DIV_W       = SUM_W;
    localparam int DCNT_W      = $clog2(DIV_W + 1);
    localparam int IDX_W       = 3;

    localparam logic [IDX_W-1:0] Q_TIME   = 3'd0;
    localparam logic [IDX_W-1:0] Q_ACC_X  = 3'd1;
    localparam logic [IDX_W-1:0] Q_ACC_Y  = 3'd2;
    localparam logic [IDX_W-1:0] Q_ACC_Z  = 3'd3;
    localparam logic [IDX_W-1:0] Q_RATE_X = 3'd4;
    localparam logic [IDX_W-1:0] Q_RATE_Y = 3'd5;
    localparam logic [IDX_W-1:0] Q_RATE_Z = 3'd6;
    localparam logic [IDX_W-1:0] Q_LAST   = Q_RATE_Z;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic in_ready;
        logic div_start;
        logic div_capture;
        logic emit;
        logic clear;
    } seq_ctrl_t;

    function automatic logic signed [SUM_W-1:0] sext_sample(input logic [FIELD_W-1:0] v);
        sext_sample = {{(SUM_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v[SAMPLE_BITS-1:0]};
    endfunction

endpackage

// ===== design/imtwa_div.sv =====
// shared bit-serial unsigned restoring divider
module imtwa_div
    import imtwa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quot_reg, quot_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    trial;
    logic              ge;

    assign shifted = {rem_reg, quot_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, divisor};
    assign trial   = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_W);
            rem_next  = '0;
            quot_next = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

// ===== design/imtwa_accum.sv =====
// batch accumulator: start time, offset sum, per-axis sums, reading and per-sensor counts
module imtwa_accum
    import imtwa_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         clear,
    input  logic [OFF_W-1:0]             period,
    input  logic [TIME_W-1:0]            timestamp,
    input  logic [FIELD_W-1:0]           acc_x,
    input  logic [FIELD_W-1:0]           acc_y,
    input  logic [FIELD_W-1:0]           acc_z,
    input  logic                         acc_valid,
    input  logic [FIELD_W-1:0]           rate_x,
    input  logic [FIELD_W-1:0]           rate_y,
    input  logic [FIELD_W-1:0]           rate_z,
    input  logic                         rate_valid,
    output logic                         pass,
    output logic                         close,
    output logic [TIME_W-1:0]            batch_start,
    output logic [SUM_W-1:0]             offset_sum,
    output logic [CNT_W-1:0]             reading_count,
    output logic [2:0][SUM_W-1:0]        acc_sum,
    output logic [CNT_W-1:0]             acc_count,
    output logic [2:0][SUM_W-1:0]        rate_sum,
    output logic [CNT_W-1:0]             rate_count
);

    logic                  open_reg, open_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic [SUM_W-1:0]      off_sum_reg, off_sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [2:0][SUM_W-1:0] acc_sum_reg, acc_sum_next;
    logic [CNT_W-1:0]      acc_cnt_reg, acc_cnt_next;
    logic [2:0][SUM_W-1:0] rate_sum_reg, rate_sum_next;
    logic [CNT_W-1:0]      rate_cnt_reg, rate_cnt_next;
    logic [TIME_W-1:0]     start_eff;
    logic [TIME_W-1:0]     diff;
    logic [OFF_W-1:0]      off;
    logic [CNT_W-1:0]      count_inc;
    logic [2:0][FIELD_W-1:0] acc_in;
    logic [2:0][FIELD_W-1:0] rate_in;

    assign acc_in  = {acc_z, acc_y, acc_x};
    assign rate_in = {rate_z, rate_y, rate_x};

    assign start_eff = open_reg ? start_reg : timestamp;
    assign diff      = timestamp - start_eff;
    assign off       = diff[TIME_W-1]       ? '0 :
                       (|diff[TIME_W-2:OFF_W]) ? '1 : diff[OFF_W-1:0];
    assign count_inc = count_reg + 1'b1;
    assign pass      = period == '0;
    assign close     = !pass && ((off >= period) || (count_inc >= CNT_W'(MAX_BATCH)));

    always_comb
    begin
        open_next     = open_reg;
        start_next    = start_reg;
        off_sum_next  = off_sum_reg;
        count_next    = count_reg;
        acc_sum_next  = acc_sum_reg;
        acc_cnt_next  = acc_cnt_reg;
        rate_sum_next = rate_sum_reg;
        rate_cnt_next = rate_cnt_reg;
        if (clear)
        begin
            open_next     = 1'b0;
            start_next    = '0;
            off_sum_next  = '0;
            count_next    = '0;
            acc_sum_next  = '0;
            acc_cnt_next  = '0;
            rate_sum_next = '0;
            rate_cnt_next = '0;
        end
        else if (accept && !pass)
        begin
            open_next    = 1'b1;
            start_next   = start_eff;
            off_sum_next = off_sum_reg + SUM_W'(off);
            count_next   = count_inc;
            if (acc_valid)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc_sum_next[i] = acc_sum_reg[i] + sext_sample(acc_in[i]);
                end
                acc_cnt_next = acc_cnt_reg + 1'b1;
            end
            if (rate_valid)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rate_sum_next[i] = rate_sum_reg[i] + sext_sample(rate_in[i]);
                end
                rate_cnt_next = rate_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            start_reg    <= '0;
            off_sum_reg  <= '0;
            count_reg    <= '0;
            acc_sum_reg  <= '0;
            acc_cnt_reg  <= '0;
            rate_sum_reg <= '0;
            rate_cnt_reg <= '0;
        end
        else
        begin
            open_reg     <= open_next;
            start_reg    <= start_next;
            off_sum_reg  <= off_sum_next;
            count_reg    <= count_next;
            acc_sum_reg  <= acc_sum_next;
            acc_cnt_reg  <= acc_cnt_next;
            rate_sum_reg <= rate_sum_next;
            rate_cnt_reg <= rate_cnt_next;
        end
    end

    assign batch_start   = start_reg;
    assign offset_sum    = off_sum_reg;
    assign reading_count = count_reg;
    assign acc_sum       = acc_sum_reg;
    assign acc_count     = acc_cnt_reg;
    assign rate_sum      = rate_sum_reg;
    assign rate_count    = rate_cnt_reg;

endmodule

// ===== design/imtwa_seq.sv =====
// sequencer stepping the shared divider through the seven quotients
module imtwa_seq
    import imtwa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             pass,
    input  logic             close,
    input  logic             div_done,
    input  logic             out_busy,
    input  logic             out_ready,
    output seq_ctrl_t        ctrl,
    output logic [IDX_W-1:0] idx
);

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             in_accept;

    assign in_accept = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = Q_TIME;
                if (in_accept)
                begin
                    if (pass)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (close)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (idx_reg == Q_LAST)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_busy || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl             = '0;
        ctrl.in_ready    = state_reg == S_IDLE;
        ctrl.div_start   = state_reg == S_LOAD;
        ctrl.div_capture = (state_reg == S_DIV) && div_done;
        ctrl.emit        = (state_reg == S_EMIT) && (!out_busy || out_ready);
        ctrl.clear       = (state_reg == S_DIV) && div_done && (idx_reg == Q_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= Q_TIME;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign idx = idx_reg;

`ifndef SYNTH
    a_pass_emit: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && pass |=> state_reg == S_EMIT)
        else $error("pass-through item did not go to emit");
    a_accum_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !pass && !close |=> state_reg == S_IDLE)
        else $error("accumulate-only item left the sequencer busy");
    a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> state_reg == S_EMIT)
        else $error("batch cleared without emitting");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= Q_LAST)
        else $error("quotient index out of range");
`endif

endmodule

// ===== design/imu_time_window_averager.sv =====
// top level: config register, batch accumulator, shared divider, output register
// an accumulate-only item leaves in_ready high; a pass-through item is staged, then emitted
// closing item: 7 quotients, each a load, 45 divider steps and a done strobe,
// computed in turn by the single serial divider, then emitted once the output register is free
// one item in flight at a time; in_ready is low from a closing or pass-through accept until its emit
// reset clears the batch and sets the period register to 0; no result is pending after reset
module imu_time_window_averager
    import imtwa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [OFF_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [TIME_W-1:0]         timestamp,
    input  logic signed [FIELD_W-1:0] acc_x,
    input  logic signed [FIELD_W-1:0] acc_y,
    input  logic signed [FIELD_W-1:0] acc_z,
    input  logic                      acc_valid,
    input  logic signed [FIELD_W-1:0] rate_x,
    input  logic signed [FIELD_W-1:0] rate_y,
    input  logic signed [FIELD_W-1:0] rate_z,
    input  logic                      rate_valid,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [TIME_W-1:0]         mean_time,
    output logic signed [FIELD_W-1:0] mean_acc_x,
    output logic signed [FIELD_W-1:0] mean_acc_y,
    output logic signed [FIELD_W-1:0] mean_acc_z,
    output logic                      acc_present,
    output logic signed [FIELD_W-1:0] mean_rate_x,
    output logic signed [FIELD_W-1:0] mean_rate_y,
    output logic signed [FIELD_W-1:0] mean_rate_z,
    output logic                      rate_present
);

    logic [OFF_W-1:0]        period_reg;
    seq_ctrl_t               ctrl;
    logic [IDX_W-1:0]        idx;
    logic                    in_accept;
    logic                    pass;
    logic                    close;
    logic [TIME_W-1:0]       batch_start;
    logic [SUM_W-1:0]        offset_sum;
    logic [CNT_W-1:0]        reading_count;
    logic [2:0][SUM_W-1:0]   acc_sum;
    logic [CNT_W-1:0]        acc_count;
    logic [2:0][SUM_W-1:0]   rate_sum;
    logic [CNT_W-1:0]        rate_count;
    logic                    div_done;
    logic [DIV_W-1:0]        quot;
    logic [SUM_W-1:0]        op_sum;
    logic [CNT_W-1:0]        op_den;
    logic                    op_neg;
    logic [DIV_W-1:0]        op_mag;
    logic [SUM_W-1:0]        q_signed;
    logic [FIELD_W-1:0]      q_field;
    logic                    acc_avg;
    logic                    rate_avg;

    logic [TIME_W-1:0]       st_time_reg;
    logic [2:0][FIELD_W-1:0] st_acc_reg;
    logic                    st_acc_pres_reg;
    logic [2:0][FIELD_W-1:0] st_rate_reg;
    logic                    st_rate_pres_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]       o_time_reg;
    logic [2:0][FIELD_W-1:0] o_acc_reg;
    logic                    o_acc_pres_reg;
    logic [2:0][FIELD_W-1:0] o_rate_reg;
    logic                    o_rate_pres_reg;

    assign in_ready  = ctrl.in_ready;
    assign in_accept = in_valid && ctrl.in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
        end
        else if (cfg_we)
        begin
            period_reg <= cfg_wdata;
        end
    end

    imtwa_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .clear         (ctrl.clear),
        .period        (period_reg),
        .timestamp     (timestamp),
        .acc_x         (acc_x),
        .acc_y         (acc_y),
        .acc_z         (acc_z),
        .acc_valid     (acc_valid),
        .rate_x        (rate_x),
        .rate_y        (rate_y),
        .rate_z        (rate_z),
        .rate_valid    (rate_valid),
        .pass          (pass),
        .close         (close),
        .batch_start   (batch_start),
        .offset_sum    (offset_sum),
        .reading_count (reading_count),
        .acc_sum       (acc_sum),
        .acc_count     (acc_count),
        .rate_sum      (rate_sum),
        .rate_count    (rate_count)
    );

    imtwa_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .pass      (pass),
        .close     (close),
        .div_done  (div_done),
        .out_busy  (out_valid_reg),
        .out_ready (out_ready),
        .ctrl      (ctrl),
        .idx       (idx)
    );

    // divider operand select
    always_comb
    begin
        op_sum = offset_sum;
        op_den = reading_count;
        op_neg = 1'b0;
        case (idx)
            Q_TIME:
            begin
                op_sum = offset_sum;
                op_den = reading_count;
            end
            Q_ACC_X:
            begin
                op_sum = acc_sum[0];
                op_den = acc_count;
                op_neg = acc_sum[0][SUM_W-1];
            end
            Q_ACC_Y:
            begin
                op_sum = acc_sum[1];
                op_den = acc_count;
                op_neg = acc_sum[1][SUM_W-1];
            end
            Q_ACC_Z:
            begin
                op_sum = acc_sum[2];
                op_den = acc_count;
                op_neg = acc_sum[2][SUM_W-1];
            end
            Q_RATE_X:
            begin
                op_sum = rate_sum[0];
                op_den = rate_count;
                op_neg = rate_sum[0][SUM_W-1];
            end
            Q_RATE_Y:
            begin
                op_sum = rate_sum[1];
                op_den = rate_count;
                op_neg = rate_sum[1][SUM_W-1];
            end
            Q_RATE_Z:
            begin
                op_sum = rate_sum[2];
                op_den = rate_count;
                op_neg = rate_sum[2][SUM_W-1];
            end
            default:
            begin
                op_sum = offset_sum;
                op_den = reading_count;
            end
        endcase
    end

    assign op_mag   = op_neg ? (~op_sum + 1'b1) : op_sum;
    assign q_signed = op_neg ? (~quot + 1'b1) : quot;
    assign q_field  = q_signed[FIELD_W-1:0];
    assign acc_avg  = acc_count != '0;
    assign rate_avg = rate_count != '0;

    imtwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (op_mag),
        .divisor  (op_den),
        .done     (div_done),
        .quot     (quot)
    );

    // result staging: newest reading on accept, quotients as they finish
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            st_time_reg      <= timestamp;
            st_acc_reg       <= {acc_z, acc_y, acc_x};
            st_acc_pres_reg  <= acc_valid;
            st_rate_reg      <= {rate_z, rate_y, rate_x};
            st_rate_pres_reg <= rate_valid;
        end
        else if (ctrl.div_capture)
        begin
            case (idx)
                Q_TIME:
                begin
                    st_time_reg      <= batch_start + TIME_W'(quot);
                    st_acc_pres_reg  <= acc_avg;
                    st_rate_pres_reg <= rate_avg;
                end
                Q_ACC_X:
                begin
                    if (acc_avg)
                    begin
                        st_acc_reg[0] <= q_field;
                    end
                end
                Q_ACC_Y:
                begin
                    if (acc_avg)
                    begin
                        st_acc_reg[1] <= q_field;
                    end
                end
                Q_ACC_Z:
                begin
                    if (acc_avg)
                    begin
                        st_acc_reg[2] <= q_field;
                    end
                end
                Q_RATE_X:
                begin
                    if (rate_avg)
                    begin
                        st_rate_reg[0] <= q_field;
                    end
                end
                Q_RATE_Y:
                begin
                    if (rate_avg)
                    begin
                        st_rate_reg[1] <= q_field;
                    end
                end
                Q_RATE_Z:
                begin
                    if (rate_avg)
                    begin
                        st_rate_reg[2] <= q_field;
                    end
                end
                default:
                begin
                    st_time_reg <= st_time_reg;
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            o_time_reg      <= st_time_reg;
            o_acc_reg       <= st_acc_reg;
            o_acc_pres_reg  <= st_acc_pres_reg;
            o_rate_reg      <= st_rate_reg;
            o_rate_pres_reg <= st_rate_pres_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mean_time    = o_time_reg;
    assign mean_acc_x   = o_acc_reg[0];
    assign mean_acc_y   = o_acc_reg[1];
    assign mean_acc_z   = o_acc_reg[2];
    assign acc_present  = o_acc_pres_reg;
    assign mean_rate_x  = o_rate_reg[0];
    assign mean_rate_y  = o_rate_reg[1];
    assign mean_rate_z  = o_rate_reg[2];
    assign rate_present = o_rate_pres_reg;

endmodule
